>>> rtl/pmq_pkg.sv
// Shared types, operation and status codes for the per-task mailbox queues.
// Used by the message RAM, the pointer file and the top-level core.
package pmq_pkg;

    localparam int TASK_LIMIT        = 16;
    localparam int MAX_TEXT_LEN      = 32;
    localparam int DEF_MAILBOX_DEPTH = 16;
    localparam int TASK_W            = 4;
    localparam int NUM_W             = 5;
    localparam int CNT_W             = 9;

    localparam logic [2:0] FUNC_SEND      = 3'd0;
    localparam logic [2:0] FUNC_RECEIVE   = 3'd1;
    localparam logic [2:0] FUNC_COUNT_ONE = 3'd2;
    localparam logic [2:0] FUNC_COUNT_ALL = 3'd3;
    localparam logic [2:0] FUNC_DELETE    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] TYPE_UNKNOWN = 2'd3;

    // One stored message.
    typedef struct packed {
        logic [TASK_W-1:0] src;
        logic [TASK_W-1:0] dest;
        logic [1:0]        mtype;
        logic [5:0]        size;
        logic [63:0]       payload;
        logic [31:0]       stamp;
    } msg_t;

    // Pointer update for one mailbox.
    typedef struct packed {
        logic              push;
        logic              pop;
        logic              flush;
        logic [TASK_W-1:0] tid;
    } ptr_cmd_t;

endpackage

>>> rtl/pmq_msg_ram.sv
// Message storage: one synchronous RAM, one write or read per cycle,
// read data registered. Depends on pmq_pkg for the message type.
module pmq_msg_ram #(
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  pmq_pkg::msg_t            wdata,
    output pmq_pkg::msg_t            rdata
);
    import pmq_pkg::*;

    msg_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

>>> rtl/pmq_ptr_file.sv
// Head pointers and fill counts of all mailboxes, held in flip-flops.
// Applies push, pop and flush commands; depends on pmq_pkg.
module pmq_ptr_file #(
    parameter int MAILBOX_DEPTH = pmq_pkg::DEF_MAILBOX_DEPTH,
    localparam int SLOT_W = (MAILBOX_DEPTH > 1) ? $clog2(MAILBOX_DEPTH) : 1,
    localparam int FILL_W = $clog2(MAILBOX_DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               clear,
    input  pmq_pkg::ptr_cmd_t  cmd,
    output logic [SLOT_W-1:0]  head,
    output logic [FILL_W-1:0]  fill
);
    import pmq_pkg::*;

    logic [SLOT_W-1:0] head_reg [TASK_LIMIT];
    logic [FILL_W-1:0] fill_reg [TASK_LIMIT];

    assign head = head_reg[cmd.tid];
    assign fill = fill_reg[cmd.tid];

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int i = 0; i < TASK_LIMIT; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else if (cmd.flush) begin
            head_reg[cmd.tid] <= '0;
            fill_reg[cmd.tid] <= '0;
        end else if (cmd.push) begin
            fill_reg[cmd.tid] <= fill + FILL_W'(1);
        end else if (cmd.pop) begin
            head_reg[cmd.tid] <= (head == SLOT_W'(MAILBOX_DEPTH - 1)) ? '0 : head + SLOT_W'(1);
            fill_reg[cmd.tid] <= fill - FILL_W'(1);
        end
    end

endmodule

>>> rtl/per_task_mailbox_queues_core.sv
// Per-task mailbox queues: decode, total count and result register.
// Every operation but a successful receive registers its result on accept; a
// successful receive passes through the message RAM read register and S_READ.
// Throughput: one item per cycle while the output is free or taken; none in S_READ.
// Reset clears all mailboxes and sets the task count to 16; a task count write
// clears all mailboxes at once. Depends on pmq_pkg, pmq_ptr_file, pmq_msg_ram.
module per_task_mailbox_queues_core #(
    parameter int MAILBOX_DEPTH = pmq_pkg::DEF_MAILBOX_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [4:0]   cfg_wdata,      // num_tasks
    input  logic         s_tvalid,
    output logic         s_tready,
    // source_task[3:0], task_id[7:4], type_id[15:8], text_length[23:16],
    // payload_word[87:24], timestamp[119:88]
    input  logic [119:0] s_tdata,
    input  logic [2:0]   s_tuser,        // func
    output logic         m_tvalid,
    input  logic         m_tready,
    // msg_count[8:0], out_source[12:9], out_dest[16:13], out_type[18:17],
    // out_size[24:19], out_payload[88:25], out_time[120:89], zeros above
    output logic [127:0] m_tdata,
    output logic [1:0]   m_tuser         // status
);
    import pmq_pkg::*;

    localparam int SLOT_W    = (MAILBOX_DEPTH > 1) ? $clog2(MAILBOX_DEPTH) : 1;
    localparam int FILL_W    = $clog2(MAILBOX_DEPTH + 1);
    localparam int SUM_W     = FILL_W + 1;
    localparam int MEM_DEPTH = TASK_LIMIT * MAILBOX_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic              state_reg, state_next;
    logic [NUM_W-1:0]  num_tasks_reg;
    logic [CNT_W-1:0]  total_reg;
    logic              m_tvalid_reg;
    logic [1:0]        m_status_reg;
    logic [CNT_W-1:0]  m_count_reg;
    msg_t              m_msg_reg;

    logic [2:0]        in_func;
    logic [TASK_W-1:0] in_src, in_tid;
    logic [7:0]        in_type, in_len;
    logic              accept;

    logic [SLOT_W-1:0] head_cur;
    logic [FILL_W-1:0] fill_cur;
    logic [SUM_W-1:0]  tail_sum;
    logic [SLOT_W-1:0] tail_slot;
    logic              tid_bad, src_bad, box_full;

    ptr_cmd_t          cmd;
    logic [1:0]        status_c;
    logic [CNT_W-1:0]  count_c;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_addr;
    msg_t              wr_msg, rd_msg;
    logic [4:0]        cfg_clamped;

    assign in_func = s_tuser;
    assign in_src  = s_tdata[3:0];
    assign in_tid  = s_tdata[7:4];
    assign in_type = s_tdata[15:8];
    assign in_len  = s_tdata[23:16];

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign tid_bad  = {1'b0, in_tid} >= num_tasks_reg;
    assign src_bad  = {1'b0, in_src} >= num_tasks_reg;
    assign box_full = fill_cur >= FILL_W'(MAILBOX_DEPTH);

    // Tail slot is head plus fill modulo the depth; the sum stays below twice it.
    assign tail_sum  = SUM_W'(head_cur) + SUM_W'(fill_cur);
    assign tail_slot = (tail_sum >= SUM_W'(MAILBOX_DEPTH))
                       ? SLOT_W'(tail_sum - SUM_W'(MAILBOX_DEPTH)) : SLOT_W'(tail_sum);

    assign mem_addr = ADDR_W'(in_tid) * ADDR_W'(MAILBOX_DEPTH)
                    + ADDR_W'((in_func == FUNC_SEND) ? tail_slot : head_cur);

    always_comb begin
        wr_msg.src     = in_src;
        wr_msg.dest    = in_tid;
        wr_msg.mtype   = (in_type <= 8'd2) ? in_type[1:0] : TYPE_UNKNOWN;
        wr_msg.size    = (in_len > 8'(MAX_TEXT_LEN)) ? 6'(MAX_TEXT_LEN) : in_len[5:0];
        wr_msg.payload = s_tdata[87:24];
        wr_msg.stamp   = s_tdata[119:88];
    end

    always_comb begin
        status_c  = ST_OK;
        count_c   = '0;
        cmd.push  = 1'b0;
        cmd.pop   = 1'b0;
        cmd.flush = 1'b0;
        cmd.tid   = in_tid;
        unique case (in_func)
            FUNC_SEND: begin
                if (tid_bad || src_bad) begin
                    status_c = ST_INVALID;
                end else if (box_full) begin
                    status_c = ST_FULL;
                end else begin
                    cmd.push = accept;
                end
            end
            FUNC_RECEIVE: begin
                if (tid_bad) begin
                    status_c = ST_INVALID;
                end else if (fill_cur == '0) begin
                    status_c = ST_EMPTY;
                end else begin
                    cmd.pop = accept;
                end
            end
            FUNC_COUNT_ONE: begin
                if (tid_bad) begin
                    status_c = ST_INVALID;
                end else begin
                    count_c = CNT_W'(fill_cur);
                end
            end
            FUNC_COUNT_ALL: begin
                count_c = total_reg;
            end
            FUNC_DELETE: begin
                if (tid_bad) begin
                    status_c = ST_INVALID;
                end else begin
                    count_c   = CNT_W'(fill_cur);
                    cmd.flush = accept;
                end
            end
            default: begin
                status_c = ST_INVALID;
            end
        endcase
    end

    assign mem_we = cmd.push;
    assign mem_re = cmd.pop;

    pmq_ptr_file #(
        .MAILBOX_DEPTH (MAILBOX_DEPTH)
    ) u_ptrs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_we),
        .cmd     (cmd),
        .head    (head_cur),
        .fill    (fill_cur)
    );

    pmq_msg_ram #(
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (wr_msg),
        .rdata (rd_msg)
    );

    assign cfg_clamped = (cfg_wdata == 5'd0) ? 5'd1
                       : (cfg_wdata > 5'(TASK_LIMIT)) ? 5'(TASK_LIMIT) : cfg_wdata;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.pop) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            num_tasks_reg <= 5'(TASK_LIMIT);
            total_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                num_tasks_reg <= cfg_clamped;
                total_reg     <= '0;
            end else if (cmd.push) begin
                total_reg <= total_reg + CNT_W'(1);
            end else if (cmd.pop) begin
                total_reg <= total_reg - CNT_W'(1);
            end else if (cmd.flush) begin
                total_reg <= total_reg - CNT_W'(fill_cur);
            end
            if ((accept && !cmd.pop) || state_reg == S_READ) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result payload: loaded directly on accept, or from the RAM in the S_READ state
    // that follows a successful receive.
    always_ff @(posedge aclk) begin
        if (state_reg == S_READ) begin
            m_status_reg <= ST_OK;
            m_count_reg  <= '0;
            m_msg_reg    <= rd_msg;
        end else if (accept && !cmd.pop) begin
            m_status_reg <= status_c;
            m_count_reg  <= count_c;
            m_msg_reg    <= '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {7'd0, m_msg_reg.stamp, m_msg_reg.payload, m_msg_reg.size,
                       m_msg_reg.mtype, m_msg_reg.dest, m_msg_reg.src, m_count_reg};

endmodule
